### design/ppfs_pkg.sv
// Shared types and constants for the point pick and frustum select unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ppfs_pkg;

    localparam int COORD_W   = 16;
    localparam int IDX_W     = 16;
    localparam int DIST_W    = 36;
    localparam int SQ_W      = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int PSUM_W    = PROD_W + 3;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PLANES    = 4;

    // Select modes; code 3 is unused and gives no results
    typedef enum logic [1:0] {
        MODE_ALL   = 2'd0,
        MODE_PICK  = 2'd1,
        MODE_PLANE = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELECT_MODE = 3'd0,
        REG_PICK_RADIUS = 3'd1,
        REG_PICK_POS    = 3'd2,
        REG_PLANE_ONE   = 3'd3,
        REG_PLANE_TWO   = 3'd4,
        REG_PLANE_THREE = 3'd5,
        REG_PLANE_FOUR  = 3'd6
    } cfg_reg_t;

    // Plane a,b,c,d in Q8.8, a in the low bits
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] a;
    } plane_t;

    // Pick point in Q8.8, x in the low bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } pick_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [DIST_W-1:0]      radius;
        pick_t                  pick;
        plane_t [PLANES-1:0]    planes;
    } cfg_t;

    // One point after the input register
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } pt_t;

    // One point after the product registers
    typedef struct packed {
        logic                               valid;
        logic                               last;
        logic [IDX_W-1:0]                   idx;
        logic [2:0][SQ_W-1:0]               sq;
        logic [PLANES-1:0][2:0][PROD_W-1:0] pp;
    } prod_t;

endpackage

### design/ppfs_cfg.sv
// Configuration register file of the point pick and frustum select unit.
// Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ppfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppfs_pkg::CFG_W-1:0]      cfg_data,
    output ppfs_pkg::cfg_t                  cfg
);

    ppfs_pkg::cfg_t cfg_reg;
    ppfs_pkg::cfg_t cfg_next;

    // Decode the write; drop writes to unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (ppfs_pkg::cfg_reg_t'(cfg_index))
                ppfs_pkg::REG_SELECT_MODE: cfg_next.mode   = cfg_data[1:0];
                ppfs_pkg::REG_PICK_RADIUS: cfg_next.radius = cfg_data[ppfs_pkg::DIST_W-1:0];
                ppfs_pkg::REG_PICK_POS:
                    cfg_next.pick = ppfs_pkg::pick_t'(cfg_data[3*ppfs_pkg::COORD_W-1:0]);
                ppfs_pkg::REG_PLANE_ONE:   cfg_next.planes[0] = ppfs_pkg::plane_t'(cfg_data);
                ppfs_pkg::REG_PLANE_TWO:   cfg_next.planes[1] = ppfs_pkg::plane_t'(cfg_data);
                ppfs_pkg::REG_PLANE_THREE: cfg_next.planes[2] = ppfs_pkg::plane_t'(cfg_data);
                ppfs_pkg::REG_PLANE_FOUR:  cfg_next.planes[3] = ppfs_pkg::plane_t'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### design/ppfs_front.sv
// Input register and point counter of the point pick and frustum select unit.
// Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [3*ppfs_pkg::COORD_W-1:0]    in_data,
    input  logic                              in_last,
    input  logic                              next_ready,
    output ppfs_pkg::pt_t                     pt
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [ppfs_pkg::IDX_W-1:0]   count_reg;
    logic [ppfs_pkg::IDX_W-1:0]   count_next;
    ppfs_pkg::pt_t                pt_reg;
    ppfs_pkg::pt_t                pt_next;
    logic                         accept;

    assign in_ready = !valid_reg || next_ready;
    assign accept   = in_valid && in_ready;

    // Number the point; restart after the last one, wrap at the counter width
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        pt_next    = pt_reg;
        if (accept)
        begin
            valid_next   = 1'b1;
            pt_next.last = in_last;
            pt_next.idx  = count_reg;
            pt_next.x    = in_data[ppfs_pkg::COORD_W-1:0];
            pt_next.y    = in_data[2*ppfs_pkg::COORD_W-1:ppfs_pkg::COORD_W];
            pt_next.z    = in_data[3*ppfs_pkg::COORD_W-1:2*ppfs_pkg::COORD_W];
            count_next   = in_last ? '0 : count_reg + 1'b1;
        end
        else if (next_ready)
        begin
            valid_next = 1'b0;
        end
        pt_next.valid = valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    always_comb
    begin
        pt       = pt_reg;
        pt.valid = valid_reg;
    end

endmodule

### design/ppfs_mult.sv
// Product stage: squared offsets to the pick point and the twelve plane products.
// Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_mult
(
    input  logic            clk,
    input  logic            rst_n,
    input  ppfs_pkg::cfg_t  cfg,
    input  ppfs_pkg::pt_t   pt,
    output logic            ready,
    input  logic            next_ready,
    output ppfs_pkg::prod_t prod
);

    localparam int DW = ppfs_pkg::COORD_W + 1;

    logic                        valid_reg;
    ppfs_pkg::prod_t             prod_reg;
    ppfs_pkg::prod_t             prod_next;
    logic signed [DW-1:0]        diff [3];
    logic signed [2*DW-1:0]      sq_full [3];
    logic signed [ppfs_pkg::COORD_W-1:0] coord [3];
    logic signed [ppfs_pkg::COORD_W-1:0] coef  [ppfs_pkg::PLANES][3];
    logic                        advance;

    assign ready   = !valid_reg || next_ready;
    assign advance = pt.valid && ready;

    assign coord[0] = pt.x;
    assign coord[1] = pt.y;
    assign coord[2] = pt.z;

    // Offsets to the pick point and their squares
    assign diff[0] = DW'(cfg.pick.x) - DW'(pt.x);
    assign diff[1] = DW'(cfg.pick.y) - DW'(pt.y);
    assign diff[2] = DW'(cfg.pick.z) - DW'(pt.z);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sq_full[k] = diff[k] * diff[k];
        for (int p = 0; p < ppfs_pkg::PLANES; p++)
        begin
            coef[p][0] = cfg.planes[p].a;
            coef[p][1] = cfg.planes[p].b;
            coef[p][2] = cfg.planes[p].c;
        end
    end

    // Form the products of the incoming point
    always_comb
    begin
        prod_next       = prod_reg;
        prod_next.valid = advance;
        if (advance)
        begin
            prod_next.last = pt.last;
            prod_next.idx  = pt.idx;
            for (int k = 0; k < 3; k++)
                prod_next.sq[k] = sq_full[k][ppfs_pkg::SQ_W-1:0];
            for (int p = 0; p < ppfs_pkg::PLANES; p++)
                for (int k = 0; k < 3; k++)
                    prod_next.pp[p][k] = ppfs_pkg::PROD_W'(coef[p][k] * coord[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= pt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            prod_reg <= prod_next;
    end

    always_comb
    begin
        prod       = prod_reg;
        prod.valid = valid_reg;
    end

endmodule

### design/ppfs_eval.sv
// Evaluation stage: distance compare, pick tracking, plane test and result register.
// Depends on ppfs_pkg.
`timescale 1ns / 1ps

module ppfs_eval
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppfs_pkg::cfg_t                cfg,
    input  ppfs_pkg::prod_t               prod,
    output logic                          ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ppfs_pkg::IDX_W-1:0]    out_index,
    output logic                          out_hit,
    output logic                          out_end
);

    localparam int PW = ppfs_pkg::PSUM_W;

    logic                          found_reg;
    logic                          found_next;
    logic [ppfs_pkg::DIST_W-1:0]   best_reg;
    logic [ppfs_pkg::DIST_W-1:0]   best_next;
    logic [ppfs_pkg::IDX_W-1:0]    best_idx_reg;
    logic [ppfs_pkg::IDX_W-1:0]    best_idx_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ppfs_pkg::IDX_W-1:0]    out_index_reg;
    logic [ppfs_pkg::IDX_W-1:0]    out_index_next;
    logic                          out_hit_reg;
    logic                          out_hit_next;
    logic                          out_end_reg;
    logic                          out_end_next;

    logic                          advance;
    logic [ppfs_pkg::DIST_W-1:0]   sq_dist;
    logic [ppfs_pkg::DIST_W-1:0]   limit;
    logic [ppfs_pkg::DIST_W-1:0]   bound;
    logic                          closer;
    logic signed [PW-1:0]          psum [ppfs_pkg::PLANES];
    logic [ppfs_pkg::PLANES-1:0]   in_plane;
    logic                          in_all;

    assign ready   = !out_valid_reg || out_ready;
    assign advance = prod.valid && ready;

    // Squared distance; three 32-bit squares never reach the 36-bit limit
    assign sq_dist = ppfs_pkg::DIST_W'(prod.sq[0]) + ppfs_pkg::DIST_W'(prod.sq[1])
                   + ppfs_pkg::DIST_W'(prod.sq[2]);
    assign limit = (cfg.radius == '0) ? '1 : cfg.radius;
    assign bound = found_reg ? best_reg : limit;
    assign closer = sq_dist < bound;

    // Plane sums in Q19.16; inside when strictly negative
    always_comb
    begin
        for (int p = 0; p < ppfs_pkg::PLANES; p++)
        begin
            psum[p] = PW'($signed(prod.pp[p][0])) + PW'($signed(prod.pp[p][1]))
                    + PW'($signed(prod.pp[p][2]))
                    + (PW'(cfg.planes[p].d) <<< 8);
            in_plane[p] = psum[p][PW-1];
        end
    end
    assign in_all = &in_plane;

    // Track the best point and clear it at the end of a run
    always_comb
    begin
        found_next    = found_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (advance)
        begin
            if (prod.last)
            begin
                found_next    = 1'b0;
                best_next     = limit;
                best_idx_next = '0;
            end
            else if (cfg.mode == ppfs_pkg::MODE_PICK && closer)
            begin
                found_next    = 1'b1;
                best_next     = sq_dist;
                best_idx_next = prod.idx;
            end
        end
    end

    // Load a new result or release the one that was taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_hit_next   = out_hit_reg;
        out_end_next   = out_end_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            out_index_next = '0;
            out_hit_next   = 1'b0;
            out_end_next   = prod.last;
            case (cfg.mode)
                ppfs_pkg::MODE_ALL:
                begin
                    out_valid_next = 1'b1;
                    out_index_next = prod.idx;
                    out_hit_next   = 1'b1;
                end
                ppfs_pkg::MODE_PICK:
                begin
                    out_valid_next = prod.last;
                    if (closer)
                    begin
                        out_index_next = prod.idx;
                        out_hit_next   = 1'b1;
                    end
                    else if (found_reg)
                    begin
                        out_index_next = best_idx_reg;
                        out_hit_next   = 1'b1;
                    end
                end
                ppfs_pkg::MODE_PLANE:
                begin
                    out_valid_next = in_all || prod.last;
                    if (in_all)
                    begin
                        out_index_next = prod.idx;
                        out_hit_next   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            best_reg      <= '1;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_hit_reg   <= out_hit_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_hit   = out_hit_reg;
    assign out_end   = out_end_reg;

`ifndef NO_ASSERTIONS
    // End of a run leaves no pick state behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && prod.last |=> !found_reg)
        else $error("pick state not cleared at end of run");

    // A result that does not close a run always names a point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_end_reg |-> out_hit_reg)
        else $error("non-closing result without a hit");

    // Pick mode gives nothing before the last point
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !prod.last && cfg.mode == ppfs_pkg::MODE_PICK |=> !out_valid_reg)
        else $error("pick mode result before end of run");

    // Pick state holds on points outside pick mode
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && cfg.mode != ppfs_pkg::MODE_PICK && !prod.last
        |=> found_reg == $past(found_reg))
        else $error("pick state changed outside pick mode");
`endif

endmodule

### design/point_pick_and_frustum_select_unit.sv
// Top level of the point pick and frustum select unit.
// Depends on ppfs_pkg, ppfs_cfg, ppfs_front, ppfs_mult and ppfs_eval.
//
//   channel   direction  contents
//   s_*       in         point x,y,z in tdata, last point in tlast
//   m_*       out        hit index in tdata, hit valid in tuser, run end in tlast
//   cfg_*     in         register write: enable, index, data
//
// One point is accepted every cycle while the result is not stalled; a point
// passes through the input, product and result registers in that order.
// The nearest-point compare and update sits in the last stage, so each point
// sees the best distance left by the point before it.
// Reset clears the point counter, pick state, configuration and stage valids,
// not data registers. A stalled result holds the pipeline back stage by stage.
`timescale 1ns / 1ps

module point_pick_and_frustum_select_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [3*ppfs_pkg::COORD_W-1:0]      s_tdata,   // coord_x, coord_y, coord_z
    input  logic                                s_tlast,   // final_point
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppfs_pkg::IDX_W-1:0]          m_tdata,   // hit_index
    output logic                                m_tuser,   // hit_valid
    output logic                                m_tlast,   // run_end
    input  logic                                cfg_we,
    input  logic [ppfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppfs_pkg::CFG_W-1:0]          cfg_data
);

    ppfs_pkg::cfg_t  cfg;
    ppfs_pkg::pt_t   pt;
    ppfs_pkg::prod_t prod;
    logic            mult_ready;
    logic            eval_ready;

    // Hold the configuration registers
    ppfs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Register the request and number the point
    ppfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .next_ready (mult_ready),
        .pt         (pt)
    );

    // Form squares and plane products
    ppfs_mult u_mult
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pt         (pt),
        .ready      (mult_ready),
        .next_ready (eval_ready),
        .prod       (prod)
    );

    // Compare, track the best point and drive the result
    ppfs_eval u_eval
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .prod      (prod),
        .ready     (eval_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (m_tdata),
        .out_hit   (m_tuser),
        .out_end   (m_tlast)
    );

endmodule
